// ----- sv/sks_pkg.sv -----
package sks_pkg;

  localparam int IDX_W   = 10;
  localparam int KEY_W   = 64;
  localparam int CNT_W   = 11;
  localparam int PROBE_W = 4;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_CMP,
    S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_key;       // store the accepted key at its index
    logic load_search;  // open the range [0, count-1]
    logic probe_rd;     // latch mid and read the table there
    logic probe_upd;    // compare, then record a hit or narrow the range
    logic load_out;     // move the result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_empty;  // lo > hi
    logic key_eq;       // probe equals the search key
    logic out_free;     // output register can take a word
  } status_t;

endpackage

// ----- sv/sorted_key_binary_search.sv -----
// Sorted key table with binary search.
// Input stream (in_*): one word per item. in_tuser is the command: write stores
// the key at the index, search looks the key up. A write makes no output word.
// Output stream (out_*): one word per search. out_tuser is the found flag.
// Configuration: cfg_wen/cfg_wdata load entry_count, the number of sorted
// keys the search covers; write it only while the block is idle.
// Search steps: each probe is a registered table read at mid followed by a
// 64-bit compare; on a miss the check state then sees the range close, and
// the result moves into the output register. With 1024 entries a search
// takes up to 11 probes.
// Flow: one search runs at a time; the input takes the next word in the
// cycle after the result is loaded, so a search holds the input until then.
// Writes go back to back. The single table port and the compare loop set
// these limits.
// The output register holds a finished word while the receiver stalls; the
// block still takes writes and starts the next search, which then waits in
// its done state until the register frees up.
// Reset clears entry_count and the control state; table contents stay
// undefined until written, and no clearing pass runs.
module sorted_key_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // [9:0] index, [73:10] key, [79:74] zero
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] match_index, [13:10] probe_count, [15:14] zero
  output logic        out_tuser,  // [0] found
  input  logic        cfg_wen,
  input  logic [10:0] cfg_wdata   // entry_count
);
  import sks_pkg::*;

  cmd_t                 cmd;
  status_t              status;
  state_t               state;
  logic [IDX_W-1:0]     match_index;
  logic [PROBE_W-1:0]   probe_count;

  // controller: sequences each probe through the check and compare states
  sks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_command(in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .state     (state)
  );

  // datapath: key table, search range, output register
  sks_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .in_index       (in_tdata[IDX_W-1:0]),
    .in_key         (in_tdata[IDX_W+KEY_W-1:IDX_W]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_found      (out_tuser),
    .out_match_index(match_index),
    .out_probe_count(probe_count)
  );

  assign out_tdata = {2'b00, probe_count, match_index};

  // a miss always reports index zero
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (match_index == '0))
    else $error("miss reported a nonzero index");

  // a hit needs at least one probe
  a_hit_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (probe_count != '0))
    else $error("hit reported without a probe");

  // never overwrite a word the receiver has not taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> status.out_free)
    else $error("output register overwritten");

  // every compare follows a table read
  a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_CMP) |-> $past(cmd.probe_rd))
    else $error("compare without a table read");

endmodule

// ----- sv/sks_ctrl.sv -----
module sks_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_command,
  output logic             in_tready,
  input  sks_pkg::status_t status,
  output sks_pkg::cmd_t    cmd,
  output sks_pkg::state_t  state
);
  import sks_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_tvalid && in_tready;
  assign state  = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_command == CMD_SEARCH) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = status.range_empty ? S_DONE : S_CMP;
      end
      S_CMP: begin
        state_nxt = status.key_eq ? S_DONE : S_CHECK;
      end
      S_DONE: begin
        if (status.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready       = 1'b0;
    cmd             = '0;
    case (state_r)
      S_IDLE: begin
        in_tready       = 1'b1;
        cmd.wr_key      = accept && in_command == CMD_WRITE;
        cmd.load_search = accept && in_command == CMD_SEARCH;
      end
      S_CHECK: cmd.probe_rd  = !status.range_empty;
      S_CMP:   cmd.probe_upd = 1'b1;
      S_DONE:  cmd.load_out  = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- sv/sks_dp.sv -----
module sks_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sks_pkg::cmd_t                 cmd,
  output sks_pkg::status_t              status,
  input  logic                          cfg_wen,
  input  logic [sks_pkg::CNT_W-1:0]     cfg_wdata,
  input  logic [sks_pkg::IDX_W-1:0]     in_index,
  input  logic [sks_pkg::KEY_W-1:0]     in_key,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic                          out_found,
  output logic [sks_pkg::IDX_W-1:0]     out_match_index,
  output logic [sks_pkg::PROBE_W-1:0]   out_probe_count
);
  import sks_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW = AW + 2;

  logic [KEY_W-1:0]       mem [TABLE_DEPTH];
  logic [KEY_W-1:0]       rdata_r;
  logic [CNT_W-1:0]       entry_count_r;
  logic [KEY_W-1:0]       key_r;
  logic signed [PW-1:0]   lo_r;
  logic signed [PW-1:0]   hi_r;
  logic signed [PW-1:0]   count;
  logic signed [PW:0]     sum;
  logic [AW-1:0]          mid;
  logic [AW-1:0]          mid_r;
  logic [PROBE_W-1:0]     probes_r;
  logic                   found_r;
  logic [IDX_W-1:0]       match_r;
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [IDX_W-1:0]       out_match_r;
  logic [PROBE_W-1:0]     out_probes_r;
  logic                   wr_in_range;

  assign count = (32'(entry_count_r) > TABLE_DEPTH) ? PW'(TABLE_DEPTH)
                                                     : PW'(entry_count_r);
  assign sum   = {lo_r[PW-1], lo_r} + {hi_r[PW-1], hi_r};
  assign mid   = sum[AW:1];
  assign wr_in_range = 32'(in_index) < TABLE_DEPTH;

  assign status.range_empty = lo_r > hi_r;
  assign status.key_eq      = rdata_r == key_r;
  assign status.out_free    = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_wen) begin
      entry_count_r <= cfg_wdata;
    end
  end

  // table port: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_key && wr_in_range) begin
      mem[AW'(in_index)] <= in_key;
    end
    if (cmd.probe_rd) begin
      rdata_r <= mem[mid];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_search) begin
      key_r    <= in_key;
      lo_r     <= '0;
      hi_r     <= count - PW'(1);
      probes_r <= '0;
      found_r  <= 1'b0;
      match_r  <= '0;
    end
    if (cmd.probe_rd) begin
      mid_r    <= mid;
      probes_r <= probes_r + PROBE_W'(1);
    end
    if (cmd.probe_upd) begin
      if (rdata_r == key_r) begin
        found_r <= 1'b1;
        match_r <= IDX_W'(mid_r);
      end else if (key_r > rdata_r) begin
        lo_r <= PW'(mid_r) + PW'(1);
      end else begin
        hi_r <= PW'(mid_r) - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_found_r  <= found_r;
      out_match_r  <= match_r;
      out_probes_r <= probes_r;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_match_r;
  assign out_probe_count = out_probes_r;

endmodule
